// ===== src/ble_adv_data_parser_core_assert.svh =====
// Assertion macros for the advertising-data parser core.
`ifndef BLE_ADV_DATA_PARSER_CORE_ASSERT_SVH
`define BLE_ADV_DATA_PARSER_CORE_ASSERT_SVH

// Check a consequence in the same cycle; expects clk and rst_n in scope.
`define BAP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bap: same-cycle check failed");

// Check a consequence in the next cycle; expects clk and rst_n in scope.
`define BAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bap: next-cycle check failed");

`endif

// ===== src/bap_pkg.sv =====
// Shared types, codes and AD type classification for the advertising-data parser.
package bap_pkg;

    // UUID de-duplication table
    localparam int UUID_SLOTS = 8;
    localparam int SLOT_IDX_W = (UUID_SLOTS > 1) ? $clog2(UUID_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(UUID_SLOTS + 1);

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_IDX_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // AD structure types
    localparam logic [7:0] AD_UUID16_PART  = 8'h02;
    localparam logic [7:0] AD_UUID16_FULL  = 8'h03;
    localparam logic [7:0] AD_UUID32_PART  = 8'h04;
    localparam logic [7:0] AD_UUID32_FULL  = 8'h05;
    localparam logic [7:0] AD_UUID128_PART = 8'h06;
    localparam logic [7:0] AD_UUID128_FULL = 8'h07;
    localparam logic [7:0] AD_NAME_SHORT   = 8'h08;
    localparam logic [7:0] AD_NAME_FULL    = 8'h09;
    localparam logic [7:0] AD_SVC_DATA16   = 8'h16;
    localparam logic [7:0] AD_SVC_DATA32   = 8'h20;
    localparam logic [7:0] AD_SVC_DATA128  = 8'h21;
    localparam logic [7:0] AD_MAKER        = 8'hFF;

    // Source UUID size codes
    localparam logic [1:0] UW_16  = 2'd0;
    localparam logic [1:0] UW_32  = 2'd1;
    localparam logic [1:0] UW_128 = 2'd2;

    // Bluetooth base UUID pieces
    localparam logic [31:0] BASE_HIGH_TAIL = 32'h0000_1000;
    localparam logic [63:0] BASE_LOW       = 64'h8000_0080_5F9B_34FB;

    typedef enum logic [2:0] {
        KIND_SVC_UUID,
        KIND_SD_UUID,
        KIND_SD_BYTE,
        KIND_COMPANY,
        KIND_MAKER_BYTE,
        KIND_NAME_BYTE,
        KIND_NAME_RESTART,
        KIND_REC_END
    } kind_t;

    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_LIST,
        ROLE_SVC_DATA,
        ROLE_MAKER,
        ROLE_NAME
    } role_t;

    typedef struct packed {
        role_t      role;
        logic [4:0] size;
        logic [1:0] width;
    } ad_class_t;

    typedef struct packed {
        kind_t       item_kind;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic [1:0]  uuid_width;
        logic [7:0]  payload_byte;
        logic        table_full;
        logic        stopped_early;
        logic        end_of_run;
    } result_t;

    // Map an AD type to its role and the size of its leading identifier
    function automatic ad_class_t classify(input logic [7:0] ad_type);
        ad_class_t c;
        c.role  = ROLE_NONE;
        c.size  = 5'd0;
        c.width = UW_16;
        case (ad_type)
            AD_UUID16_PART, AD_UUID16_FULL:
            begin
                c.role = ROLE_LIST;
                c.size = 5'd2;
            end
            AD_UUID32_PART, AD_UUID32_FULL:
            begin
                c.role  = ROLE_LIST;
                c.size  = 5'd4;
                c.width = UW_32;
            end
            AD_UUID128_PART, AD_UUID128_FULL:
            begin
                c.role  = ROLE_LIST;
                c.size  = 5'd16;
                c.width = UW_128;
            end
            AD_SVC_DATA16:
            begin
                c.role = ROLE_SVC_DATA;
                c.size = 5'd2;
            end
            AD_SVC_DATA32:
            begin
                c.role  = ROLE_SVC_DATA;
                c.size  = 5'd4;
                c.width = UW_32;
            end
            AD_SVC_DATA128:
            begin
                c.role  = ROLE_SVC_DATA;
                c.size  = 5'd16;
                c.width = UW_128;
            end
            AD_MAKER:
            begin
                c.role = ROLE_MAKER;
                c.size = 5'd2;
            end
            AD_NAME_SHORT, AD_NAME_FULL:
            begin
                c.role = ROLE_NAME;
            end
            default:
            begin
                c.role = ROLE_NONE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== src/bap_if.sv =====
// Stream interfaces for scan-record bytes in and parser results out.
interface bap_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] record_byte;
    logic       first_byte;
    logic [7:0] record_length;
    logic       last_byte;

    modport source (output valid, record_byte, first_byte, record_length, last_byte,
                    input ready);
    modport sink (input valid, record_byte, first_byte, record_length, last_byte,
                  output ready);
endinterface

interface bap_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  item_kind;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    logic [1:0]  uuid_width;
    logic [7:0]  payload_byte;
    logic        table_full;
    logic        stopped_early;
    logic        end_of_run;

    modport source (output valid, item_kind, uuid_high, uuid_low, uuid_width,
                    payload_byte, table_full, stopped_early, end_of_run,
                    input ready);
    modport sink (input valid, item_kind, uuid_high, uuid_low, uuid_width,
                  payload_byte, table_full, stopped_early, end_of_run,
                  output ready);
endinterface

// ===== src/ble_adv_data_parser_core.sv =====
// Advertising-data parser core: walks AD structures of a scan record byte by byte.
//
//   channel  | dir | handshake     | item
//   ---------+-----+---------------+--------------------------------------------
//   scan     | in  | valid/ready   | one record byte with first/last marks, length
//   result   | out | valid/ready   | one parser result (uuid, id, byte, end)
//
// One byte is parsed per cycle; its state update lands at the accepting edge.
// A byte yields up to two items (a data item plus a record end) that enter a
// four-entry result queue; scan.ready is high while two entries are free, so
// with the result side ready a new byte is taken every cycle.
// Duplicate UUIDs are found by a parallel compare over the eight-slot table.
// Reset clears all parse state and the queue; no clearing pass is needed.
`include "ble_adv_data_parser_core_assert.svh"

module ble_adv_data_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    bap_scan_if.sink     scan,
    bap_result_if.source result
);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_STOP
    } phase_t;

    // Parse state
    logic [7:0]                      pos_reg,   pos_next;
    phase_t                          phase_reg, phase_next;
    logic [7:0]                      len_reg,   len_next;
    logic [7:0]                      slen_reg,  slen_next;
    logic [7:0]                      stype_reg, stype_next;
    logic [7:0]                      off_reg,   off_next;
    logic [63:0]                     asm_hi_reg, asm_hi_next;
    logic [63:0]                     asm_lo_reg, asm_lo_next;
    logic                            name_reg,  name_next;
    logic [bap_pkg::SLOT_CNT_W-1:0]  seen_count_reg, seen_count_next;

    // UUID table
    logic [63:0] seen_hi_mem [bap_pkg::UUID_SLOTS];
    logic [63:0] seen_lo_mem [bap_pkg::UUID_SLOTS];
    logic        seen_we;
    logic [bap_pkg::UUID_SLOTS-1:0] seen_hit;
    logic        dup;

    // Result queue
    bap_pkg::result_t               oq_mem [bap_pkg::OQ_DEPTH];
    logic [bap_pkg::OQ_IDX_W-1:0]   oq_wr_reg, oq_wr_next;
    logic [bap_pkg::OQ_IDX_W-1:0]   oq_rd_reg, oq_rd_next;
    logic [bap_pkg::OQ_CNT_W-1:0]   oq_count_reg, oq_count_next;
    logic [bap_pkg::OQ_IDX_W-1:0]   oq_wr_plus1;
    bap_pkg::result_t               oq_head;

    // Per-byte working values
    logic                            scan_acc;
    logic                            pop;
    logic [7:0]                      b;
    logic [7:0]                      e_pos, e_len, e_slen, e_stype, e_off;
    phase_t                          e_phase;
    logic [63:0]                     e_asm_hi, e_asm_lo;
    logic                            e_name;
    logic [bap_pkg::SLOT_CNT_W-1:0]  e_count;
    bap_pkg::ad_class_t              cls;
    logic [7:0]                      d;
    logic [7:0]                      size8;
    logic [63:0]                     byte_shifted;
    logic [63:0]                     acc_hi, acc_lo;
    logic [63:0]                     wide_hi, wide_lo;
    logic                            active;
    logic                            id_role;
    bap_pkg::result_t                r0, r_end;
    logic                            r0_valid;
    logic                            push0, push1;

    assign scan_acc = scan.valid && scan.ready;
    assign pop      = result.valid && result.ready;
    assign b        = scan.record_byte;

    // Apply a first-byte clear before parsing the byte
    always_comb
    begin
        e_pos    = scan.first_byte ? 8'd0 : pos_reg;
        e_phase  = scan.first_byte ? PH_LEN : phase_reg;
        e_len    = scan.first_byte ? scan.record_length : len_reg;
        e_slen   = scan.first_byte ? 8'd0 : slen_reg;
        e_stype  = scan.first_byte ? 8'd0 : stype_reg;
        e_off    = scan.first_byte ? 8'd0 : off_reg;
        e_asm_hi = scan.first_byte ? 64'd0 : asm_hi_reg;
        e_asm_lo = scan.first_byte ? 64'd0 : asm_lo_reg;
        e_name   = scan.first_byte ? 1'b0 : name_reg;
        e_count  = scan.first_byte ? '0 : seen_count_reg;
    end

    // Assemble the identifier byte and widen it with the base UUID
    always_comb
    begin
        cls          = bap_pkg::classify(e_stype);
        d            = e_slen - 8'd1;
        size8        = {3'd0, cls.size};
        byte_shifted = {56'd0, b} << {e_off[2:0], 3'b000};
        acc_hi       = e_asm_hi;
        acc_lo       = e_asm_lo;
        if (e_off[3])
        begin
            acc_hi = e_asm_hi | byte_shifted;
        end
        else
        begin
            acc_lo = e_asm_lo | byte_shifted;
        end
        if (cls.size != 5'd16)
        begin
            wide_hi = {acc_lo[31:0], bap_pkg::BASE_HIGH_TAIL};
            wide_lo = bap_pkg::BASE_LOW;
        end
        else
        begin
            wide_hi = acc_hi;
            wide_lo = acc_lo;
        end
    end

    // Compare the widened UUID against every filled slot
    always_comb
    begin
        for (int i = 0; i < bap_pkg::UUID_SLOTS; i++)
        begin
            seen_hit[i] = (bap_pkg::SLOT_CNT_W'(i) < e_count) &&
                          (seen_hi_mem[i] == wide_hi) && (seen_lo_mem[i] == wide_lo);
        end
        dup = |seen_hit;
    end

    // Parse one byte: next state and up to two result items
    always_comb
    begin
        pos_next        = e_pos;
        phase_next      = e_phase;
        len_next        = e_len;
        slen_next       = e_slen;
        stype_next      = e_stype;
        off_next        = e_off;
        asm_hi_next     = e_asm_hi;
        asm_lo_next     = e_asm_lo;
        name_next       = e_name;
        seen_count_next = e_count;
        seen_we         = 1'b0;
        r0              = '0;
        r0_valid        = 1'b0;
        r_end           = '0;
        active          = (e_phase != PH_STOP) && (e_pos < e_len);
        id_role         = (cls.role == bap_pkg::ROLE_LIST) ||
                          (cls.role == bap_pkg::ROLE_SVC_DATA) ||
                          (cls.role == bap_pkg::ROLE_MAKER);

        if (active)
        begin
            case (e_phase)
                PH_LEN:
                begin
                    if (b == 8'd0 || ({1'b0, e_pos} + {1'b0, b}) >= {1'b0, e_len})
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        slen_next  = b;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    stype_next  = b;
                    off_next    = 8'd0;
                    asm_hi_next = 64'd0;
                    asm_lo_next = 64'd0;
                    if (e_slen <= 8'd1)
                    begin
                        // empty complete name drops the earlier name
                        if (b == bap_pkg::AD_NAME_FULL)
                        begin
                            name_next = 1'b0;
                        end
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (id_role && d >= size8)
                    begin
                        if (e_off < size8)
                        begin
                            asm_hi_next = acc_hi;
                            asm_lo_next = acc_lo;
                            if (e_off == size8 - 8'd1)
                            begin
                                case (cls.role)
                                    bap_pkg::ROLE_MAKER:
                                    begin
                                        r0_valid     = 1'b1;
                                        r0.item_kind = bap_pkg::KIND_COMPANY;
                                        r0.uuid_low  = {48'd0, acc_lo[15:0]};
                                    end
                                    bap_pkg::ROLE_SVC_DATA:
                                    begin
                                        r0_valid      = 1'b1;
                                        r0.item_kind  = bap_pkg::KIND_SD_UUID;
                                        r0.uuid_high  = wide_hi;
                                        r0.uuid_low   = wide_lo;
                                        r0.uuid_width = cls.width;
                                    end
                                    bap_pkg::ROLE_LIST:
                                    begin
                                        // drop zero and already-seen uuids
                                        if ((wide_hi != 64'd0 || wide_lo != 64'd0) && !dup)
                                        begin
                                            r0_valid      = 1'b1;
                                            r0.item_kind  = bap_pkg::KIND_SVC_UUID;
                                            r0.uuid_high  = wide_hi;
                                            r0.uuid_low   = wide_lo;
                                            r0.uuid_width = cls.width;
                                            if (e_count < bap_pkg::SLOT_CNT_W'(bap_pkg::UUID_SLOTS))
                                            begin
                                                seen_we         = 1'b1;
                                                seen_count_next = e_count + 1'b1;
                                            end
                                            else
                                            begin
                                                r0.table_full = 1'b1;
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                        r0_valid = 1'b0;
                                    end
                                endcase
                            end
                        end
                        else if (cls.role == bap_pkg::ROLE_SVC_DATA)
                        begin
                            r0_valid        = 1'b1;
                            r0.item_kind    = bap_pkg::KIND_SD_BYTE;
                            r0.payload_byte = b;
                        end
                        else if (cls.role == bap_pkg::ROLE_MAKER)
                        begin
                            r0_valid        = 1'b1;
                            r0.item_kind    = bap_pkg::KIND_MAKER_BYTE;
                            r0.payload_byte = b;
                        end
                    end
                    else if (cls.role == bap_pkg::ROLE_NAME)
                    begin
                        // decide on the first name byte; bit 0 of the assembly keeps it
                        if (e_off == 8'd0)
                        begin
                            if (e_stype == bap_pkg::AD_NAME_FULL)
                            begin
                                r0_valid        = 1'b1;
                                r0.item_kind    = e_name ? bap_pkg::KIND_NAME_RESTART
                                                         : bap_pkg::KIND_NAME_BYTE;
                                r0.payload_byte = b;
                                asm_lo_next     = 64'd1;
                                name_next       = 1'b1;
                            end
                            else if (!e_name)
                            begin
                                r0_valid        = 1'b1;
                                r0.item_kind    = bap_pkg::KIND_NAME_BYTE;
                                r0.payload_byte = b;
                                asm_lo_next     = 64'd1;
                                name_next       = 1'b1;
                            end
                            else
                            begin
                                asm_lo_next = 64'd0;
                            end
                        end
                        else if (e_asm_lo[0])
                        begin
                            r0_valid        = 1'b1;
                            r0.item_kind    = bap_pkg::KIND_NAME_BYTE;
                            r0.payload_byte = b;
                        end
                    end
                    off_next = e_off + 8'd1;
                    if (({1'b0, e_off} + 9'd1) >= {1'b0, d})
                    begin
                        phase_next = PH_LEN;
                    end
                end
                default:
                begin
                    phase_next = e_phase;
                end
            endcase
            if (e_pos != 8'hFF)
            begin
                pos_next = e_pos + 8'd1;
            end
        end

        // Record end reports whether a structure was cut off
        r_end.item_kind     = bap_pkg::KIND_REC_END;
        r_end.stopped_early = (phase_next != PH_LEN);
        r_end.end_of_run    = 1'b1;
        if (scan.last_byte)
        begin
            phase_next = PH_STOP;
        end
    end

    // Queue bookkeeping: push up to two items, pop one
    assign push0       = scan_acc && (r0_valid || scan.last_byte);
    assign push1       = scan_acc && r0_valid && scan.last_byte;
    assign oq_wr_plus1 = oq_wr_reg + 1'b1;
    assign oq_head     = oq_mem[oq_rd_reg];

    always_comb
    begin
        oq_wr_next    = oq_wr_reg + bap_pkg::OQ_IDX_W'(push0) + bap_pkg::OQ_IDX_W'(push1);
        oq_rd_next    = oq_rd_reg + bap_pkg::OQ_IDX_W'(pop);
        oq_count_next = oq_count_reg + bap_pkg::OQ_CNT_W'(push0) + bap_pkg::OQ_CNT_W'(push1)
                        - bap_pkg::OQ_CNT_W'(pop);
    end

    // Take a byte while two queue entries are free
    assign scan.ready = (oq_count_reg <= bap_pkg::OQ_CNT_W'(bap_pkg::OQ_DEPTH - 2));

    assign result.valid         = (oq_count_reg != '0);
    assign result.item_kind     = oq_head.item_kind;
    assign result.uuid_high     = oq_head.uuid_high;
    assign result.uuid_low      = oq_head.uuid_low;
    assign result.uuid_width    = oq_head.uuid_width;
    assign result.payload_byte  = oq_head.payload_byte;
    assign result.table_full    = oq_head.table_full;
    assign result.stopped_early = oq_head.stopped_early;
    assign result.end_of_run    = oq_head.end_of_run;

    // Hold parse state and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 8'd0;
            phase_reg      <= PH_LEN;
            len_reg        <= 8'd0;
            slen_reg       <= 8'd0;
            stype_reg      <= 8'd0;
            off_reg        <= 8'd0;
            asm_hi_reg     <= 64'd0;
            asm_lo_reg     <= 64'd0;
            name_reg       <= 1'b0;
            seen_count_reg <= '0;
            oq_wr_reg      <= '0;
            oq_rd_reg      <= '0;
            oq_count_reg   <= '0;
        end
        else
        begin
            if (scan_acc)
            begin
                pos_reg        <= pos_next;
                phase_reg      <= phase_next;
                len_reg        <= len_next;
                slen_reg       <= slen_next;
                stype_reg      <= stype_next;
                off_reg        <= off_next;
                asm_hi_reg     <= asm_hi_next;
                asm_lo_reg     <= asm_lo_next;
                name_reg       <= name_next;
                seen_count_reg <= seen_count_next;
            end
            oq_wr_reg    <= oq_wr_next;
            oq_rd_reg    <= oq_rd_next;
            oq_count_reg <= oq_count_next;
        end
    end

    // Store new uuids and queued items
    always_ff @(posedge clk)
    begin
        if (scan_acc && seen_we)
        begin
            seen_hi_mem[e_count[bap_pkg::SLOT_IDX_W-1:0]] <= wide_hi;
            seen_lo_mem[e_count[bap_pkg::SLOT_IDX_W-1:0]] <= wide_lo;
        end
        if (push0)
        begin
            oq_mem[oq_wr_reg] <= r0_valid ? r0 : r_end;
        end
        if (push1)
        begin
            oq_mem[oq_wr_plus1] <= r_end;
        end
    end

    // Checks
    `BAP_ASSERT_SAME(a_oq_bound, 1'b1, oq_count_reg <= bap_pkg::OQ_CNT_W'(bap_pkg::OQ_DEPTH))
    `BAP_ASSERT_SAME(a_seen_bound, 1'b1,
                     seen_count_reg <= bap_pkg::SLOT_CNT_W'(bap_pkg::UUID_SLOTS))
    `BAP_ASSERT_NEXT(a_end_stops, scan_acc && scan.last_byte, phase_reg == PH_STOP)
    `BAP_ASSERT_NEXT(a_first_pos, scan_acc && scan.first_byte, pos_reg <= 8'd1)
    `BAP_ASSERT_SAME(a_full_list_only, result.valid && result.table_full,
                     result.item_kind == bap_pkg::KIND_SVC_UUID)

endmodule
